/* rtl/dtw_pkg.sv */
// Shared types, field layout and constants for the decision tree walker.
package dtw_pkg;

   // Default sizing handed to the top level
   localparam int DEF_RULE_DEPTH   = 4096;
   localparam int DEF_NUM_FEATURES = 16;
   localparam int DEF_MAX_STEPS    = 255;

   // Fixed field widths
   localparam int NODE_ADDR_W = 12;
   localparam int BYTE_W      = 8;
   localparam int FEAT_VEC_W  = 128;
   localparam int MAX_FEAT    = FEAT_VEC_W / BYTE_W;

   // Request tdata layout, lowest field first
   localparam int REQ_TDATA_W     = 192;
   localparam int REQ_NODE_ADDR_LO = 0;
   localparam int REQ_FEATURE_LO   = 12;
   localparam int REQ_BYTE_LO      = 20;
   localparam int REQ_TRUE_LO      = 28;
   localparam int REQ_FALSE_LO     = 40;
   localparam int REQ_START_LO     = 52;
   localparam int REQ_FEAT_LO      = 64;

   // Response tdata layout: phone, then steps_taken
   localparam int RSP_TDATA_W   = 16;
   localparam int STEPS_W       = 8;

   // Configuration port
   localparam int CSR_ADDR_W = 3;
   localparam int CSR_DATA_W = 32;
   localparam logic       REG_END_MARKER   = 1'b0;
   localparam logic [7:0] END_MARKER_RESET = 8'hFF;

   // Request kind carried in tuser
   typedef enum logic {
      MODE_WRITE    = 1'b0,
      MODE_CLASSIFY = 1'b1
   } mode_type;

   // One rule node as held in the store
   typedef struct packed {
      logic [BYTE_W-1:0]      feat;
      logic [BYTE_W-1:0]      cmp;
      logic [NODE_ADDR_W-1:0] true_next;
      logic [NODE_ADDR_W-1:0] false_next;
   } node_type;

   // Store access strobes from the walker
   typedef struct packed {
      logic rd_en;
      logic wr_en;
   } store_cmd_type;

endpackage

/* rtl/decision_tree_walker.sv */
// Top level of the decision tree walker: config registers and block wiring.
//
// Requests arrive on req_*. tuser = 0 writes one node into the rule store
// (no response); tuser = 1 classifies a feature vector starting
// at start_addr and yields one response on rsp_* with the leaf phone, the
// number of inner nodes visited, and an overrun flag in tuser.
// A classify request occupies the block until its walk ends: the root is
// read when the request is accepted, then one rule store read per node
// visited, since each successor address depends on the node just read.
// The next request is accepted in the cycle after the response is loaded;
// a write request is taken every cycle while idle.
// The response sits in an output register; if the receiver stalls, the
// next request is still accepted, and a second finished walk waits on the
// leaf until the register frees.
// Reset returns the sequencer to idle, drops any pending response and sets
// end_marker to 255. Rule store contents are undefined until written, and
// no clearing pass runs. end_marker sits at csr byte address 0.
// RULE_DEPTH must be a power of two.
module decision_tree_walker import dtw_pkg::*; #(
   parameter int RULE_DEPTH   = DEF_RULE_DEPTH,
   parameter int NUM_FEATURES = DEF_NUM_FEATURES,
   parameter int MAX_STEPS    = DEF_MAX_STEPS
) (
   input  logic                   clock,
   input  logic                   reset,
   // Request channel
   input  logic                   req_tvalid,
   output logic                   req_tready,
   input  logic                   req_tuser,   // mode
   // node_addr, node_feature, node_byte, node_true_next, node_false_next,
   // start_addr, features_low, features_high
   input  logic [REQ_TDATA_W-1:0] req_tdata,
   // Response channel
   output logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   output logic [RSP_TDATA_W-1:0] rsp_tdata,   // phone, steps_taken
   output logic                   rsp_tuser,   // overrun
   // Configuration port
   input  logic                   csr_psel,
   input  logic                   csr_penable,
   input  logic                   csr_pwrite,
   input  logic [CSR_ADDR_W-1:0]  csr_paddr,
   input  logic [CSR_DATA_W-1:0]  csr_pwdata,
   output logic [CSR_DATA_W-1:0]  csr_prdata,
   output logic                   csr_pready
);

   localparam int AW = $clog2(RULE_DEPTH);

   logic [BYTE_W-1:0] end_marker_ff;
   logic              csr_wr;
   store_cmd_type     store_cmd;
   logic [AW-1:0]     store_wr_addr;
   logic [AW-1:0]     store_rd_addr;
   node_type          store_wr_data;
   node_type          store_rd_data;

   // Register file: end_marker only
   assign csr_pready = 1'b1;
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite && csr_pready;

   always_ff @(posedge clock) begin
      if (reset) begin
         end_marker_ff <= END_MARKER_RESET;
      end else if (csr_wr && (csr_paddr[2] == REG_END_MARKER)) begin
         end_marker_ff <= csr_pwdata[BYTE_W-1:0];
      end
   end

   assign csr_prdata = (csr_paddr[2] == REG_END_MARKER) ? CSR_DATA_W'(end_marker_ff) : '0;

   dtw_walker #(
      .RULE_DEPTH   (RULE_DEPTH),
      .NUM_FEATURES (NUM_FEATURES),
      .MAX_STEPS    (MAX_STEPS)
   ) u_walker (
      .clock         (clock),
      .reset         (reset),
      .end_marker    (end_marker_ff),
      .req_tvalid    (req_tvalid),
      .req_tready    (req_tready),
      .req_tuser     (req_tuser),
      .req_tdata     (req_tdata),
      .rsp_tvalid    (rsp_tvalid),
      .rsp_tready    (rsp_tready),
      .rsp_tdata     (rsp_tdata),
      .rsp_tuser     (rsp_tuser),
      .store_cmd     (store_cmd),
      .store_wr_addr (store_wr_addr),
      .store_wr_data (store_wr_data),
      .store_rd_addr (store_rd_addr),
      .store_rd_data (store_rd_data)
   );

   dtw_rule_store #(
      .RULE_DEPTH (RULE_DEPTH)
   ) u_rule_store (
      .clock     (clock),
      .store_cmd (store_cmd),
      .wr_addr   (store_wr_addr),
      .wr_data   (store_wr_data),
      .rd_addr   (store_rd_addr),
      .rd_data   (store_rd_data)
   );

endmodule

/* rtl/dtw_rule_store.sv */
// Rule store: single-port-write, registered-read memory of tree nodes.
module dtw_rule_store import dtw_pkg::*; #(
   parameter int RULE_DEPTH = DEF_RULE_DEPTH
) (
   input  logic                          clock,
   input  store_cmd_type                 store_cmd,
   input  logic [$clog2(RULE_DEPTH)-1:0] wr_addr,
   input  node_type                      wr_data,
   input  logic [$clog2(RULE_DEPTH)-1:0] rd_addr,
   output node_type                      rd_data
);

   node_type mem [RULE_DEPTH];
   node_type rd_data_ff;

   // Write one node
   always_ff @(posedge clock) begin
      if (store_cmd.wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // Registered read; hold data when no read is issued
   always_ff @(posedge clock) begin
      if (store_cmd.rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

/* rtl/dtw_walker.sv */
// Walk sequencer: takes requests, drives the rule store, builds responses.
module dtw_walker import dtw_pkg::*; #(
   parameter int RULE_DEPTH   = DEF_RULE_DEPTH,
   parameter int NUM_FEATURES = DEF_NUM_FEATURES,
   parameter int MAX_STEPS    = DEF_MAX_STEPS
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic [BYTE_W-1:0]             end_marker,
   input  logic                          req_tvalid,
   output logic                          req_tready,
   input  logic                          req_tuser,
   input  logic [REQ_TDATA_W-1:0]        req_tdata,
   output logic                          rsp_tvalid,
   input  logic                          rsp_tready,
   output logic [RSP_TDATA_W-1:0]        rsp_tdata,
   output logic                          rsp_tuser,
   output store_cmd_type                 store_cmd,
   output logic [$clog2(RULE_DEPTH)-1:0] store_wr_addr,
   output node_type                      store_wr_data,
   output logic [$clog2(RULE_DEPTH)-1:0] store_rd_addr,
   input  node_type                      store_rd_data
);

   localparam int AW = $clog2(RULE_DEPTH);
   localparam int FW = $clog2(NUM_FEATURES);
   localparam int SW = $clog2(MAX_STEPS + 1);

   typedef enum logic {
      ST_IDLE,
      ST_WALK
   } state_type;

   state_type             state_ff;
   logic [BYTE_W-1:0]     feat_ff [NUM_FEATURES];
   logic [SW-1:0]         steps_ff;
   logic                  rsp_tvalid_ff;
   logic [BYTE_W-1:0]     rsp_phone_ff;
   logic [STEPS_W-1:0]    rsp_steps_ff;
   logic                  rsp_overrun_ff;

   logic                  accept;
   logic                  classify;
   logic                  is_leaf;
   logic                  at_limit;
   logic                  walk_done;
   logic                  out_free;
   logic                  rsp_load;
   logic [BYTE_W-1:0]     feat_val;
   logic [NODE_ADDR_W-1:0] next_raw;
   logic [FEAT_VEC_W-1:0] feat_vec;

   // Fold a 12-bit node address onto the store depth
   function automatic logic [AW-1:0] fold_addr(input logic [NODE_ADDR_W-1:0] a);
      logic [AW+NODE_ADDR_W-1:0] wide;
      wide = (AW + NODE_ADDR_W)'(a);
      return wide[AW-1:0];
   endfunction

   // Request side
   assign req_tready = (state_ff == ST_IDLE);
   assign accept     = req_tvalid && req_tready;
   assign classify   = (req_tuser == MODE_CLASSIFY);
   assign feat_vec   = req_tdata[REQ_FEAT_LO +: FEAT_VEC_W];

   // Evaluate the node returned by the store
   assign is_leaf  = (store_rd_data.feat == end_marker);
   assign at_limit = (steps_ff == SW'(MAX_STEPS));
   assign feat_val = (store_rd_data.feat < BYTE_W'(NUM_FEATURES))
                     ? feat_ff[store_rd_data.feat[FW-1:0]] : '0;
   assign next_raw = (feat_val == store_rd_data.cmp) ? store_rd_data.true_next
                                                     : store_rd_data.false_next;
   assign walk_done = (state_ff == ST_WALK) && (is_leaf || at_limit);
   assign out_free  = !rsp_tvalid_ff || rsp_tready;
   assign rsp_load  = walk_done && out_free;

   // Store access: writes only from idle, reads at start and per step
   assign store_cmd.wr_en = accept && !classify;
   assign store_cmd.rd_en = (accept && classify) ||
                            ((state_ff == ST_WALK) && !is_leaf && !at_limit);
   assign store_wr_addr = fold_addr(req_tdata[REQ_NODE_ADDR_LO +: NODE_ADDR_W]);
   assign store_wr_data = '{
      feat:       req_tdata[REQ_FEATURE_LO +: BYTE_W],
      cmp:        req_tdata[REQ_BYTE_LO +: BYTE_W],
      true_next:  req_tdata[REQ_TRUE_LO +: NODE_ADDR_W],
      false_next: req_tdata[REQ_FALSE_LO +: NODE_ADDR_W]
   };
   assign store_rd_addr = (state_ff == ST_IDLE)
                          ? fold_addr(req_tdata[REQ_START_LO +: NODE_ADDR_W])
                          : fold_addr(next_raw);

   // Sequencer state and response register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         rsp_tvalid_ff <= 1'b0;
      end else begin
         if (rsp_load) begin
            rsp_tvalid_ff <= 1'b1;
         end else if (rsp_tvalid_ff && rsp_tready) begin
            rsp_tvalid_ff <= 1'b0;
         end
         unique case (state_ff)
            ST_IDLE: begin
               if (accept && classify) begin
                  state_ff <= ST_WALK;
                  steps_ff <= '0;
                  for (int i = 0; i < NUM_FEATURES; i++) begin
                     feat_ff[i] <= feat_vec[BYTE_W*i +: BYTE_W];
                  end
               end
            end
            ST_WALK: begin
               if (walk_done) begin
                  // Hold the leaf in the store output until the response slot frees
                  if (out_free) begin
                     rsp_phone_ff   <= is_leaf ? store_rd_data.cmp : '0;
                     rsp_steps_ff   <= STEPS_W'(steps_ff);
                     rsp_overrun_ff <= !is_leaf;
                     state_ff       <= ST_IDLE;
                  end
               end else begin
                  steps_ff <= steps_ff + 1'b1;
               end
            end
            default: state_ff <= ST_IDLE;
         endcase
      end
   end

   assign rsp_tvalid = rsp_tvalid_ff;
   assign rsp_tdata  = {rsp_steps_ff, rsp_phone_ff};
   assign rsp_tuser  = rsp_overrun_ff;

   // Node writes never interleave with a walk
   a_write_only_idle: assert property (@(posedge clock) disable iff (reset)
      store_cmd.wr_en |-> state_ff == ST_IDLE)
      else $error("rule store written during a walk");

   // Step count stays within the limit
   a_steps_bounded: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_WALK |-> steps_ff <= SW'(MAX_STEPS))
      else $error("step counter past limit");

   // Overrun responses report the limit and no phone
   a_overrun_shape: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tuser) |->
         (rsp_tdata[15:8] == STEPS_W'(MAX_STEPS) && rsp_tdata[7:0] == '0))
      else $error("overrun response malformed");

   // A response only appears at the end of a walk
   a_rsp_from_walk: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_tvalid_ff) |-> $past(state_ff == ST_WALK))
      else $error("response raised outside a walk");

endmodule
